// File: design/fst_pkg.sv
package fst_pkg;

  // One input item: a packet's key and per-packet attributes.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_l4_port;
    logic [15:0] dst_l4_port;
    logic [7:0]  protocol;
    logic [11:0] frame_length;
    logic [31:0] arrival_ms;
    logic        fwd_flag;
    logic [15:0] tcp_wnd;
  } in_item_t;

  // One result item: the flow's statistics after the update.
  typedef struct packed {
    logic [5:0]  flow_slot;
    logic        created;
    logic        dropped;
    logic [31:0] packet_count;
    logic [31:0] mean_len;
    logic [31:0] payload_total;
    logic [31:0] forward_count;
    logic [31:0] receive_count;
    logic [31:0] min_gap;
    logic [31:0] max_gap;
    logic [31:0] duration;
    logic [15:0] window_avg;
  } out_item_t;

  // Per-flow record held in the table memory.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  protocol;
    logic [31:0] pkt_cnt;
    logic [31:0] byte_cnt;
    logic [31:0] pay_cnt;
    logic [31:0] fwd_cnt;
    logic [31:0] rcv_cnt;
    logic [31:0] gap_min;
    logic [31:0] gap_max;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic [15:0] win_avg;
  } entry_t;

  localparam logic [7:0]  AllowReset = 8'd54;
  localparam logic [31:0] GapNone    = 32'hFFFF_FFFF;
  localparam logic [7:0]  ProtoTcp   = 8'd6;

endpackage

// File: design/fst_queue.sv
// Two-entry item queue between the front and the back.
module fst_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  fst_pkg::in_item_t   wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output fst_pkg::in_item_t   rd_data_o
);

  fst_pkg::in_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: design/fst_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fst_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d, trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  assign trial  = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  // One shift and trial subtract per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// File: design/fst_back.sv
// Back part: walks the table for a match, updates the entry, divides, and
// holds the result in an output register.
module fst_back #(
  parameter int FlowSlots = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  fst_pkg::in_item_t   item_i,
  input  logic [7:0]          allow_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output fst_pkg::out_item_t  res_o
);

  localparam int IdxW = (FlowSlots > 1) ? $clog2(FlowSlots) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  fst_pkg::entry_t    mem [FlowSlots];
  fst_pkg::entry_t    rd_q, ent_q, ent_d;
  fst_pkg::in_item_t  it_q;
  fst_pkg::out_item_t res_q, res_d;
  logic [FlowSlots-1:0] valid_q;
  logic [2:0]  st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] slot_q, slot_d, free_q, free_d;
  logic        free_ok_q, free_ok_d, created_q, created_d;
  logic        wr_en, div_start, div_done, out_busy_q, out_busy_d;
  logic [31:0] quot, gap, pay;
  logic [31:0] ports;
  logic [IdxW-1:0] idx_lo;

  assign ports  = {it_q.src_l4_port, it_q.dst_l4_port};
  assign idx_lo = idx_q;
  assign item_ready_o = (st_q == StIdle);
  assign res_valid_o  = out_busy_q;
  assign res_o        = res_q;

  fst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ent_q.byte_cnt),
    .divisor_i  (ent_q.pkt_cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Update arithmetic for the chosen entry.
  always_comb begin
    gap = (ent_q.last_time != 32'd0) ? (it_q.arrival_ms - ent_q.last_time) : 32'd0;
    pay = ({20'd0, it_q.frame_length} > {24'd0, allow_i})
        ? ({20'd0, it_q.frame_length} - {24'd0, allow_i}) : 32'd0;
  end

  // Sequencer: scan the slots in turn, each with a read and a compare state, then update, divide and emit.
  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    free_d     = free_q;
    free_ok_d  = free_ok_q;
    created_d  = created_q;
    ent_d      = ent_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    out_busy_d = out_busy_q && !res_ready_i;
    case (st_q)
      StIdle: begin
        if (item_valid_i) begin
          idx_d     = '0;
          free_ok_d = 1'b0;
          created_d = 1'b0;
          st_d      = StRead;
        end
      end
      StRead: begin
        st_d = StCmp;
      end
      StCmp: begin
        if (valid_q[idx_lo] && rd_q.src_addr == it_q.src_addr &&
            rd_q.dst_addr == it_q.dst_addr && rd_q.ports == ports &&
            rd_q.protocol == it_q.protocol) begin
          slot_d = idx_lo;
          ent_d  = rd_q;
          st_d   = StUpd;
        end else begin
          if (!valid_q[idx_lo] && !free_ok_q) begin
            free_d    = idx_lo;
            free_ok_d = 1'b1;
          end
          if (idx_q == IdxW'(FlowSlots - 1)) begin
            if (free_ok_d) begin
              slot_d           = free_d;
              created_d        = 1'b1;
              ent_d.src_addr   = it_q.src_addr;
              ent_d.dst_addr   = it_q.dst_addr;
              ent_d.ports      = ports;
              ent_d.protocol   = it_q.protocol;
              ent_d.pkt_cnt    = '0;
              ent_d.byte_cnt   = '0;
              ent_d.pay_cnt    = '0;
              ent_d.fwd_cnt    = '0;
              ent_d.rcv_cnt    = '0;
              ent_d.gap_min    = fst_pkg::GapNone;
              ent_d.gap_max    = '0;
              ent_d.win_avg    = '0;
              ent_d.first_time = it_q.arrival_ms;
              ent_d.last_time  = it_q.arrival_ms;
              st_d             = StUpd;
            end else if (!out_busy_q) begin
              res_d         = '0;
              res_d.dropped = 1'b1;
              out_busy_d    = 1'b1;
              st_d          = StIdle;
            end
          end else begin
            idx_d = idx_q + IdxW'(1);
            st_d  = StRead;
          end
        end
      end
      StUpd: begin
        ent_d.pkt_cnt  = ent_q.pkt_cnt + 32'd1;
        ent_d.byte_cnt = ent_q.byte_cnt + {20'd0, it_q.frame_length};
        ent_d.pay_cnt  = ent_q.pay_cnt + pay;
        if (it_q.fwd_flag) begin
          ent_d.fwd_cnt = ent_q.fwd_cnt + 32'd1;
        end else begin
          ent_d.rcv_cnt = ent_q.rcv_cnt + 32'd1;
        end
        if (gap != 32'd0 && gap < ent_q.gap_min) begin
          ent_d.gap_min = gap;
        end
        if (gap > ent_q.gap_max) begin
          ent_d.gap_max = gap;
        end
        ent_d.last_time = it_q.arrival_ms;
        if (ent_q.protocol == fst_pkg::ProtoTcp && it_q.tcp_wnd != 16'd0) begin
          ent_d.win_avg = 16'(({1'b0, ent_q.win_avg} + {1'b0, it_q.tcp_wnd}) >> 1);
        end
        st_d = StDiv;
      end
      StDiv: begin
        // Entry is final here; write it back and start the divide.
        wr_en     = 1'b1;
        div_start = 1'b1;
        st_d      = StOut;
      end
      StOut: begin
        // Held until the quotient is in and the output register is free.
        st_d = StOut;
      end
      default: st_d = StIdle;
    endcase
  end

  // Result capture waits for the divider and a free output register.
  logic div_have_q, div_have_d;
  logic [31:0] quot_q;
  always_comb begin
    div_have_d = div_have_q;
    if (st_q == StDiv) begin
      div_have_d = 1'b0;
    end else if (div_done) begin
      div_have_d = 1'b1;
    end
  end

  fst_pkg::out_item_t res_fin;
  always_comb begin
    res_fin               = '0;
    res_fin.flow_slot     = 6'(slot_q);
    res_fin.created       = created_q;
    res_fin.packet_count  = ent_q.pkt_cnt;
    res_fin.mean_len      = (ent_q.pkt_cnt != 32'd0) ? quot_q : 32'd0;
    res_fin.payload_total = ent_q.pay_cnt;
    res_fin.forward_count = ent_q.fwd_cnt;
    res_fin.receive_count = ent_q.rcv_cnt;
    res_fin.min_gap       = ent_q.gap_min;
    res_fin.max_gap       = ent_q.gap_max;
    res_fin.duration      = it_q.arrival_ms - ent_q.first_time;
    res_fin.window_avg    = ent_q.win_avg;
  end

  logic fin_now;
  assign fin_now = (st_q == StOut) && div_have_q && !out_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      idx_q      <= '0;
      free_ok_q  <= 1'b0;
      created_q  <= 1'b0;
      valid_q    <= '0;
      out_busy_q <= 1'b0;
      div_have_q <= 1'b0;
    end else begin
      st_q       <= fin_now ? StIdle : st_d;
      idx_q      <= idx_d;
      free_ok_q  <= free_ok_d;
      created_q  <= created_d;
      div_have_q <= div_have_d;
      out_busy_q <= out_busy_d || fin_now;
      if (wr_en) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  // Payload registers and the table memory.
  always_ff @(posedge clk_i) begin
    if (item_valid_i && st_q == StIdle) begin
      it_q <= item_i;
    end
    slot_q <= slot_d;
    free_q <= free_d;
    ent_q  <= ent_d;
    res_q  <= fin_now ? res_fin : res_d;
    if (div_done) begin
      quot_q <= quot;
    end
    if (wr_en) begin
      mem[slot_q] <= ent_q;
    end
    rd_q <= mem[idx_lo];
  end

endmodule

// File: design/fst_front.sv
// Front part: takes items and the allowance register, feeds the queue.
module fst_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fst_pkg::in_item_t  in_data_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output fst_pkg::in_item_t  q_data_o,
  output logic [7:0]         allow_o
);

  logic [7:0] allow_q, allow_d;

  assign in_ready_o  = q_ready_i;
  assign q_valid_o   = in_valid_i;
  assign q_data_o    = in_data_i;
  assign cfg_ready_o = 1'b1;
  assign allow_o     = allow_q;

  // Allowance register write.
  always_comb begin
    allow_d = cfg_valid_i ? cfg_data_i : allow_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= fst_pkg::AllowReset;
    end else begin
      allow_q <= allow_d;
    end
  end

endmodule

// File: design/flow_statistics_table_core.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (fst_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (fst_pkg::out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (header allowance)
//
// The back scans the table for the item's key; a match at slot k ends the scan there,
// else the whole table is scanned. Each slot takes a read state and a compare state;
// then come an update state and a write-back state that starts the shift divider;
// the quotient is then registered and, with the output register free, the result loaded.
// A dropped item ends after the full scan, once the output register is free. Reset
// clears the valid marks and sets the allowance to AllowReset at once; no clearing
// pass. A queue of two items lets the input keep accepting while the back works,
// and the output register holds a result while the next item is processed.
module flow_statistics_table_core #(
  parameter int FlowSlots = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fst_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fst_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  fst_pkg::in_item_t  fq_data, bq_data;
  logic [7:0]         allow;

  fst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_data_o    (fq_data),
    .allow_o     (allow)
  );

  fst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_data_o  (bq_data)
  );

  fst_back #(
    .FlowSlots (FlowSlots)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bq_valid),
    .item_ready_o (bq_ready),
    .item_i       (bq_data),
    .allow_i      (allow),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (out_data_o)
  );

endmodule
